// ----- rtl/clkp_pkg.sv -----
// shared types, constants and the keyword table of the command line keyword parser
// no dependencies
`default_nettype none
package clkp_pkg;

  localparam int WORD_MAX = 16;
  localparam int LINE_MAX = 256;
  localparam int NUM_KEYS = 23;
  localparam int LEN_W    = $clog2(WORD_MAX + 1);
  localparam int IDX_W    = $clog2(WORD_MAX);
  localparam int CNT_W    = $clog2(LINE_MAX + 1);

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_FIN  = 2'd2;

  localparam logic [4:0] NO_COMMAND = 5'd23;
  localparam logic [7:0] ESC_RESET  = 8'd27;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NL    = 8'h0a;

  // keyword text right-justified: char p of a key of length L is at byte L-1-p
  localparam logic [8*WORD_MAX-1:0] KEY_TEXT [NUM_KEYS] = '{
    "++addr", "++auto", "++clr", "++eoi", "++eos", {"++eot_", "enable"},
    {"++eot_", "char"}, "++ifc", "++llo", "++loc", "++lon", "++mode", "++read",
    {"++read_", "tmo_ms"}, "++rst", {"++save_", "cfg"}, {"++factory_", "reset"},
    "++spoll", "++srq", "++status", "++trg", "++ver", "++help"
  };
  localparam logic [IDX_W-1:0] KEY_LEN [NUM_KEYS] = '{
    4'd6, 4'd6, 4'd5, 4'd5, 4'd5, 4'd12, 4'd10, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6,
    4'd6, 4'd13, 4'd5, 4'd10, 4'd15, 4'd7, 4'd5, 4'd8, 4'd5, 4'd5, 4'd6
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_line;
  } clkp_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       byte_value;
    logic [4:0]       command_code;
    logic [CNT_W-1:0] char_count;
    logic             last;
  } clkp_out_t;

  typedef struct packed {
    logic latch;
    logic len_clear;
    logic store;
    logic rep_step;
    logic data_cur;
    logic dropnl;
    logic emit_cmd;
    logic emit_fin;
  } clkp_cmd_t;

  typedef struct packed {
    logic is_plus;
    logic is_space;
    logic is_nl;
    logic eol;
    logic len_full;
    logic hit;
    logic rep_last;
    logic out_free;
  } clkp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/clkp_dp.sv -----
// datapath: byte latch, word buffer, keyword match mask, unescape, counters, output register
// depends on clkp_pkg
`default_nettype none
module clkp_dp import clkp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire clkp_in_t   in_beat,
  input  wire logic       cfg_valid,
  input  wire logic [7:0] cfg_data,
  input  wire logic       out_ready,
  input  wire clkp_cmd_t  cmd,
  output clkp_stat_t      stat,
  output logic            out_valid,
  output clkp_out_t       out_beat
);

  logic [7:0]          escape_char;
  logic [7:0]          cur_byte;
  logic                cur_eol;
  logic [7:0]          word_buf [WORD_MAX];
  logic [LEN_W-1:0]    word_len;
  logic [NUM_KEYS-1:0] key_mask, key_mask_next;
  logic [IDX_W-1:0]    rep_idx;
  logic                esc_pend;
  logic [4:0]          line_cmd;
  logic [CNT_W-1:0]    data_count;

  logic [7:0]  x;
  logic        x_eol, do_data, emit_data;
  logic [4:0]  hit_code;
  logic        hit;
  logic [IDX_W-1:0] cpos;

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      cpos = KEY_LEN[k] - 4'd1 - word_len[IDX_W-1:0];
      key_mask_next[k] = ((word_len == '0) ? 1'b1 : key_mask[k]) &&
                         ({1'b0, KEY_LEN[k]} > word_len) &&
                         (KEY_TEXT[k][{cpos, 3'b000} +: 8] == cur_byte);
    end
  end

  always_comb begin
    hit = 1'b0;
    hit_code = NO_COMMAND;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (key_mask[k] && word_len == {1'b0, KEY_LEN[k]}) begin
        hit = 1'b1;
        hit_code = 5'(k);
      end
    end
  end

  always_comb begin
    x = cmd.rep_step ? word_buf[rep_idx] : cur_byte;
    x_eol = cmd.rep_step ? 1'b0 : cur_eol;
    do_data = cmd.rep_step | cmd.data_cur;
    emit_data = do_data && (esc_pend ||
                !(x == escape_char || (x_eol && cmd.dropnl && x == CHAR_NL)));
  end

  always_comb begin
    stat.is_plus  = cur_byte == CHAR_PLUS;
    stat.is_space = cur_byte == CHAR_SPACE;
    stat.is_nl    = cur_byte == CHAR_NL;
    stat.eol      = cur_eol;
    stat.len_full = word_len == LEN_W'(WORD_MAX);
    stat.hit      = hit;
    stat.rep_last = ({1'b0, rep_idx} + LEN_W'(1)) == word_len;
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_char <= ESC_RESET;
      word_len    <= '0;
      esc_pend    <= 1'b0;
      line_cmd    <= NO_COMMAND;
      data_count  <= '0;
      out_valid   <= 1'b0;
      rep_idx     <= '0;
    end else begin
      if (cfg_valid) escape_char <= cfg_data;
      if (cmd.latch) begin
        cur_byte <= in_beat.data_byte;
        cur_eol  <= in_beat.end_of_line;
        rep_idx  <= '0;
      end
      if (cmd.emit_cmd || cmd.emit_fin || cmd.len_clear ||
          (cmd.rep_step && stat.rep_last)) begin
        word_len <= '0;
      end else if (cmd.store) begin
        word_len <= word_len + LEN_W'(1);
      end
      if (cmd.store) begin
        word_buf[word_len[IDX_W-1:0]] <= cur_byte;
        key_mask <= key_mask_next;
      end
      if (cmd.rep_step) rep_idx <= rep_idx + IDX_W'(1);
      if (do_data) begin
        if (esc_pend) esc_pend <= 1'b0;
        else if (x == escape_char) esc_pend <= 1'b1;
      end
      if (emit_data || cmd.emit_cmd || cmd.emit_fin) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (emit_data) begin
        out_beat  <= '{kind: KIND_DATA, byte_value: x, command_code: 5'd0,
                       char_count: '0, last: 1'b0};
        if (data_count < CNT_W'(LINE_MAX)) data_count <= data_count + CNT_W'(1);
      end
      if (cmd.emit_cmd) begin
        out_beat  <= '{kind: KIND_CMD, byte_value: 8'd0, command_code: hit_code,
                       char_count: '0, last: 1'b0};
        line_cmd  <= hit_code;
      end
      if (cmd.emit_fin) begin
        out_beat   <= '{kind: KIND_FIN, byte_value: 8'd0, command_code: line_cmd,
                        char_count: data_count, last: 1'b1};
        line_cmd   <= NO_COMMAND;
        data_count <= '0;
        esc_pend   <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/clkp_ctrl.sv -----
// controller: parse mode and sequencing of the datapath steps for one input beat
// depends on clkp_pkg
`default_nettype none
module clkp_ctrl import clkp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire clkp_stat_t stat,
  output clkp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    M_LINE_START, M_PREFIX, M_WORD, M_ARG, M_PLAIN
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_CLOSE, S_REPLAY, S_CMD, S_DATA, S_FIN
  } state_t;

  state_t state, state_next;
  mode_t  mode, mode_next;
  logic   data_after, data_after_next;
  logic   dropnl, dropnl_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    mode_next = mode;
    data_after_next = data_after;
    dropnl_next = dropnl;
    cmd = '0;
    cmd.dropnl = dropnl;
    unique case (state)
      S_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        unique case (mode)
          M_LINE_START: begin
            if (stat.is_plus && !stat.eol) begin
              // word length is already zero at line start
              cmd.store = 1'b1;
              mode_next = M_PREFIX;
              state_next = S_IDLE;
            end else begin
              cmd.len_clear = 1'b1;
              mode_next = M_PLAIN;
              dropnl_next = 1'b0;
              state_next = S_DATA;
            end
          end
          M_PREFIX: begin
            if (stat.is_plus) begin
              cmd.store = 1'b1;
              mode_next = M_WORD;
              data_after_next = 1'b0;
              state_next = stat.eol ? S_CLOSE : S_IDLE;
            end else begin
              mode_next = M_PLAIN;
              dropnl_next = 1'b0;
              data_after_next = 1'b1;
              state_next = S_REPLAY;
            end
          end
          M_WORD: begin
            dropnl_next = 1'b1;
            if (stat.is_space || (stat.eol && stat.is_nl)) begin
              data_after_next = 1'b1;
              state_next = S_CLOSE;
            end else if (!stat.len_full) begin
              cmd.store = 1'b1;
              data_after_next = 1'b0;
              state_next = stat.eol ? S_CLOSE : S_IDLE;
            end else begin
              // overlong word, cannot match any keyword
              mode_next = M_ARG;
              data_after_next = 1'b1;
              state_next = S_REPLAY;
            end
          end
          M_ARG: begin
            dropnl_next = 1'b1;
            state_next = S_DATA;
          end
          default: begin
            mode_next = M_PLAIN;
            dropnl_next = 1'b0;
            state_next = S_DATA;
          end
        endcase
      end
      S_CLOSE: begin
        mode_next = M_ARG;
        state_next = stat.hit ? S_CMD : S_REPLAY;
      end
      S_CMD: begin
        if (stat.out_free) begin
          cmd.emit_cmd = 1'b1;
          state_next = stat.eol ? S_FIN : S_IDLE;
        end
      end
      S_REPLAY: begin
        if (stat.out_free) begin
          cmd.rep_step = 1'b1;
          if (stat.rep_last)
            state_next = data_after ? S_DATA : (stat.eol ? S_FIN : S_IDLE);
        end
      end
      S_DATA: begin
        if (stat.out_free) begin
          cmd.data_cur = 1'b1;
          state_next = stat.eol ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.emit_fin = 1'b1;
          mode_next = M_LINE_START;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= M_LINE_START;
      data_after <= 1'b0;
      dropnl <= 1'b0;
    end else begin
      state <= state_next;
      mode <= mode_next;
      data_after <= data_after_next;
      dropnl <= dropnl_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/command_line_keyword_parser_core.sv -----
// top level of the command line keyword parser: controller plus datapath
// depends on clkp_pkg, clkp_ctrl, clkp_dp
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_beat (data_byte, end_of_line)
// out      output     out_valid / out_ready  out_beat (kind .. last)
// cfg      input      cfg_valid / cfg_ready  cfg_data (escape_char)
//
// a beat that only extends the word is accepted (S_IDLE) and decoded (S_EVAL); a
// byte sent on as data adds an S_DATA step even when the escape rule drops it, a
// word close adds S_CLOSE, then S_CMD for the command or one S_REPLAY step per
// byte replayed through the single word buffer read port; line end adds S_FIN.
// each result leaves through a one-deep output register; a stalled output holds
// the sequencer. synchronous reset, no clearing pass; cfg is always ready
`default_nettype none
module command_line_keyword_parser_core import clkp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire clkp_in_t   in_beat,
  output logic            out_valid,
  input  wire logic       out_ready,
  output clkp_out_t       out_beat,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  clkp_cmd_t  cmd;
  clkp_stat_t stat;

  assign cfg_ready = 1'b1;

  clkp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  clkp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_beat   (in_beat),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

endmodule
`default_nettype wire

// ----- bench/tb_command_line_keyword_parser_core.sv -----
`timescale 1ns / 100ps
// testbench for command_line_keyword_parser_core: directed lines, then random lines
// checked against a line parser model kept here; depends on clkp_pkg and the rtl
module tb_command_line_keyword_parser_core;
  import clkp_pkg::*;

  localparam int MODE_START  = 0;
  localparam int MODE_PREFIX = 1;
  localparam int MODE_WORD   = 2;
  localparam int MODE_ARG    = 3;
  localparam int MODE_PLAIN  = 4;
  localparam int DRAIN_WAIT  = 40;
  localparam int HOLD_LEN    = 90;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  clkp_in_t   in_beat = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  clkp_out_t  out_beat;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  command_line_keyword_parser_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_beat(in_beat),
    .out_valid(out_valid), .out_ready(out_ready), .out_beat(out_beat),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  string keywords [NUM_KEYS] = '{
    "++addr", "++auto", "++clr", "++eoi", "++eos", string'({"++eot_", "enable"}),
    string'({"++eot_", "char"}), "++ifc", "++llo", "++loc", "++lon", "++mode",
    "++read", string'({"++read_", "tmo_ms"}), "++rst", string'({"++save_", "cfg"}),
    string'({"++factory_", "reset"}), "++spoll", "++srq", "++status",
    "++trg", "++ver", "++help"
  };

  // parser state mirrored here
  clkp_out_t  pending_results [$];
  logic [7:0] esc_byte = ESC_RESET;
  int         mode = MODE_START;
  logic [7:0] word_buf [WORD_MAX];
  int         word_len = 0;
  bit         esc_pending = 0;
  logic [4:0] line_cmd = NO_COMMAND;
  int         line_count = 0;

  int  errors = 0;
  int  snd_idle = 0;
  int  rcv_idle = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;
  int  hold_cnt = 0;

  function automatic void add_result(logic [1:0] k, logic [7:0] b, logic [4:0] c,
                                     int n, logic l);
    clkp_out_t r;
    r.kind = k;
    r.byte_value = b;
    r.command_code = c;
    r.char_count = n[CNT_W-1:0];
    r.last = l;
    pending_results.push_back(r);
  endfunction

  function automatic void unescape_byte(logic [7:0] b, bit eol, bit dropnl);
    if (esc_pending) begin
      esc_pending = 0;
    end else if (b == esc_byte) begin
      esc_pending = 1;
      return;
    end else if (eol && dropnl && b == CHAR_NL) begin
      return;
    end
    add_result(KIND_DATA, b, 5'd0, 0, 1'b0);
    if (line_count < LINE_MAX) line_count++;
  endfunction

  function automatic void replay_word(bit dropnl);
    for (int i = 0; i < word_len && i < WORD_MAX; i++)
      unescape_byte(word_buf[i], 0, dropnl);
    word_len = 0;
  endfunction

  function automatic logic [4:0] lookup_word();
    bit same;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (keywords[i].len() == word_len) begin
        same = 1;
        for (int p = 0; p < word_len; p++)
          if (word_buf[p] != keywords[i][p]) same = 0;
        if (same) return i[4:0];
      end
    end
    return NO_COMMAND;
  endfunction

  function automatic bit finish_word();
    logic [4:0] code;
    code = lookup_word();
    mode = MODE_ARG;
    if (code != NO_COMMAND) begin
      line_cmd = code;
      word_len = 0;
      add_result(KIND_CMD, 8'd0, code, 0, 1'b0);
      return 1;
    end
    replay_word(1);
    return 0;
  endfunction

  function automatic void parse_byte(logic [7:0] b, bit eol);
    case (mode)
      MODE_START: begin
        word_len = 0;
        if (b == CHAR_PLUS && !eol) begin
          word_buf[0] = b;
          word_len = 1;
          mode = MODE_PREFIX;
        end else begin
          mode = MODE_PLAIN;
          unescape_byte(b, eol, 0);
        end
      end
      MODE_PREFIX: begin
        if (b == CHAR_PLUS) begin
          word_buf[1] = b;
          word_len = 2;
          mode = MODE_WORD;
          if (eol) void'(finish_word());
        end else begin
          mode = MODE_PLAIN;
          replay_word(0);
          unescape_byte(b, eol, 0);
        end
      end
      MODE_WORD: begin
        if (b == CHAR_SPACE || (eol && b == CHAR_NL)) begin
          if (!finish_word()) unescape_byte(b, eol, 1);
        end else if (word_len < WORD_MAX) begin
          word_buf[word_len] = b;
          word_len++;
          if (eol) void'(finish_word());
        end else begin
          mode = MODE_ARG;
          replay_word(1);
          unescape_byte(b, eol, 1);
        end
      end
      MODE_ARG: unescape_byte(b, eol, 1);
      default: begin
        mode = MODE_PLAIN;
        unescape_byte(b, eol, 0);
      end
    endcase
    if (eol) begin
      add_result(KIND_FIN, 8'd0, line_cmd, line_count, 1'b1);
      mode = MODE_START;
      word_len = 0;
      esc_pending = 0;
      line_cmd = NO_COMMAND;
      line_count = 0;
    end
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_cnt <= HOLD_LEN;
      hold_done <= 1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    clkp_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %p", out_beat);
      end else begin
        want = pending_results.pop_front();
        if (out_beat !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected kind %0d byte %h cmd %0d count %0d last %0d",
                     want.kind, want.byte_value, want.command_code, want.char_count,
                     want.last);
            $display("          got kind %0d byte %h cmd %0d count %0d last %0d",
                     out_beat.kind, out_beat.byte_value, out_beat.command_code,
                     out_beat.char_count, out_beat.last);
          end
        end
      end
    end
  end

  // called at a rising edge, returns at the edge where the beat is taken
  task automatic send_byte(logic [7:0] b, bit eol);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat.data_byte <= b;
    in_beat.end_of_line <= eol;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    parse_byte(b, eol);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_escape(logic [7:0] v);
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    esc_byte = v;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return esc_byte;
      1: return CHAR_SPACE;
      2: return CHAR_NL;
      3: return CHAR_PLUS;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_line(logic [7:0] text [$]);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic random_line();
    logic [7:0] text [$];
    int k, n;
    k = $urandom_range(9);
    if (k <= 6) begin
      text.push_back(CHAR_PLUS);
      text.push_back(CHAR_PLUS);
      if (k <= 3) begin
        n = $urandom_range(NUM_KEYS - 1);
        for (int p = 2; p < keywords[n].len(); p++) text.push_back(keywords[n][p]);
      end else if (k == 4) begin
        // escape inside the word
        text.push_back(esc_byte);
        n = $urandom_range(1, 6);
        repeat (n) text.push_back(8'($urandom_range(97, 122)));
      end else begin
        n = $urandom_range(1, 20);
        repeat (n) text.push_back(8'($urandom_range(97, 122)));
      end
      case ($urandom_range(3))
        0: ;
        1: text.push_back(CHAR_NL);
        default: begin
          text.push_back(CHAR_SPACE);
          n = $urandom_range(0, 6);
          repeat (n) text.push_back(pick_byte());
          if ($urandom_range(1)) text.push_back(CHAR_NL);
        end
      endcase
    end else if (k == 7) begin
      text.push_back(CHAR_PLUS);
      n = $urandom_range(0, 3);
      repeat (n) text.push_back(pick_byte());
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) text.push_back(k == 8 ? pick_byte() : 8'($urandom_range(255)));
    end
    send_line(text);
  endtask

  typedef struct packed {
    logic [7:0]       b;
    logic             eol;
    logic             typed;
    logic [4:0]       cmd;
    logic [CNT_W-1:0] cnt;
  } dir_row_t;

  // every line end carries the typed line-finished beat
  dir_row_t dir_tab [22] = '{
    '{8'h41, 1'b1, 1'b1, NO_COMMAND, 9'd1},
    '{8'h2b, 1'b1, 1'b1, NO_COMMAND, 9'd1},
    '{8'h2b, 1'b0, 1'b0, 5'd0, 9'd0},
    '{8'h2b, 1'b1, 1'b1, NO_COMMAND, 9'd2},
    '{8'h2b, 1'b0, 1'b0, 5'd0, 9'd0},
    '{8'h2b, 1'b0, 1'b0, 5'd0, 9'd0},
    '{8'h63, 1'b0, 1'b0, 5'd0, 9'd0},
    '{8'h6c, 1'b0, 1'b0, 5'd0, 9'd0},
    '{8'h72, 1'b0, 1'b0, 5'd0, 9'd0},
    '{8'h0a, 1'b1, 1'b1, 5'd2, 9'd0},
    '{8'h2b, 1'b0, 1'b0, 5'd0, 9'd0},
    '{8'h78, 1'b1, 1'b1, NO_COMMAND, 9'd2},
    '{8'h1b, 1'b1, 1'b1, NO_COMMAND, 9'd0},
    '{8'hff, 1'b1, 1'b1, NO_COMMAND, 9'd1},
    '{8'h00, 1'b1, 1'b1, NO_COMMAND, 9'd1},
    '{8'h2b, 1'b0, 1'b0, 5'd0, 9'd0},
    '{8'h2b, 1'b0, 1'b0, 5'd0, 9'd0},
    '{8'h76, 1'b0, 1'b0, 5'd0, 9'd0},
    '{8'h65, 1'b0, 1'b0, 5'd0, 9'd0},
    '{8'h72, 1'b0, 1'b0, 5'd0, 9'd0},
    '{8'h20, 1'b0, 1'b0, 5'd0, 9'd0},
    '{8'h61, 1'b1, 1'b1, 5'd21, 9'd1}
  };

  initial begin
    logic [7:0] esc_vals [3] = '{8'h00, 8'hff, 8'h5c};
    clkp_out_t  fin;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].b, dir_tab[i].eol);
      if (dir_tab[i].typed) begin
        fin.kind = KIND_FIN;
        fin.byte_value = 8'd0;
        fin.command_code = dir_tab[i].cmd;
        fin.char_count = dir_tab[i].cnt;
        fin.last = 1'b1;
        pending_results[pending_results.size() - 1] = fin;
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      write_escape(esc_vals[ph]);
      snd_idle = (ph == 0) ? 15 : (ph == 1) ? 70 : 0;
      rcv_idle = (ph == 0) ? 70 : (ph == 1) ? 15 : 0;
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 6; n++) begin
        random_line();
        if (ph == 1 && n == 3) drain();
      end
    end

    write_escape(ESC_RESET);
    for (int n = 0; n < 3; n++) random_line();

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
